@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the core top level; compiled out when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/core/cmam_pkg.sv @@
// ----------------------------------------------------------------------------
// cmam_pkg
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cmam_pkg;

  localparam int unsigned DATA_W              = 16;
  localparam int unsigned WINDOW_LENGTH_DEF   = 100;
  localparam int unsigned APB_ADDR_W          = 3;
  localparam int unsigned APB_DATA_W          = 32;
  localparam int unsigned REG_IDX_W           = 1;

  localparam logic [REG_IDX_W-1:0] REG_LOW_POWER_THRESHOLD = 1'b0;
  localparam logic [DATA_W-1:0]    THRESHOLD_RESET         = 16'd50;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_READ     = 6'b000010,
    ST_UPDATE   = 6'b000100,
    ST_DIV_INIT = 6'b001000,
    ST_DIVIDE   = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/cmam_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmam_ctrl
// Sequencer: capture, ring read, sum update, divide, result hand-off.
// ----------------------------------------------------------------------------
module cmam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output cmam_pkg::cmd_t    cmd_o,
  input  cmam_pkg::status_t status_i
);

  cmam_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmam_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      cmam_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = cmam_pkg::ST_READ;
        end
      end
      cmam_pkg::ST_READ: begin
        state_d = cmam_pkg::ST_UPDATE;
      end
      cmam_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = cmam_pkg::ST_DIV_INIT;
      end
      cmam_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = cmam_pkg::ST_DIVIDE;
      end
      cmam_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        state_d        = cmam_pkg::ST_FINISH;
      end
      cmam_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = cmam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cmam_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == cmam_pkg::ST_IDLE);

endmodule

@@ rtl/core/cmam_datapath.sv @@
// ----------------------------------------------------------------------------
// cmam_datapath
// Sample ring, running sum, reciprocal divider and output register.
// ----------------------------------------------------------------------------
module cmam_datapath #(
  parameter int unsigned WINDOW_LENGTH = cmam_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmam_pkg::cmd_t              cmd_i,
  output cmam_pkg::status_t           status_o,
  input  logic [cmam_pkg::DATA_W-1:0] sample_i,
  input  logic [cmam_pkg::DATA_W-1:0] threshold_i,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cmam_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser
);

  localparam int unsigned DW     = cmam_pkg::DATA_W;
  localparam int unsigned PTR_W  = $clog2(WINDOW_LENGTH);
  localparam int unsigned SUM_W  = DW + PTR_W;
  // Reciprocal scale: floor(x * RECIP / 2^SHIFT) is exact for all x below 2^SUM_W.
  localparam int unsigned SHIFT  = SUM_W + PTR_W;
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  localparam longint unsigned RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);
  localparam logic [SUM_W-1:0] LEN_WIDE = SUM_W'(WINDOW_LENGTH);
  localparam logic [SUM_W:0]   RECIP    = (SUM_W + 1)'(RECIP_WIDE);

  logic [DW-1:0]     ring_mem [WINDOW_LENGTH];
  logic [DW-1:0]     rd_q;
  logic [DW-1:0]     sample_q;
  logic [DW-1:0]     first_q;
  logic              primed_q, wrapped_q;
  logic [PTR_W-1:0]  wp_q;
  logic [SUM_W-1:0]  sum_q;
  logic              neg_q;
  logic [SUM_W-1:0]  mag_q;
  logic [DW-1:0]     quot_q;
  logic              out_valid_q;
  logic [DW-1:0]     out_data_q;
  logic              out_flag_q;

  logic [DW-1:0]     old_entry;
  logic [SUM_W-1:0]  sample_wide, old_wide, prime_sum, next_sum;
  logic [PROD_W-1:0] product;
  logic [DW-1:0]     avg;

  // Ring memory: one write per update once primed, one registered read every cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && primed_q) begin
      ring_mem[wp_q] <= sample_q;
    end
    rd_q <= ring_mem[wp_q];
  end

  // Until the ring wraps after priming, unwritten slots count as the first sample.
  assign old_entry   = wrapped_q ? rd_q : first_q;
  assign sample_wide = {{(SUM_W - DW){sample_q[DW-1]}}, sample_q};
  assign old_wide    = {{(SUM_W - DW){old_entry[DW-1]}}, old_entry};
  assign prime_sum   = sample_wide * LEN_WIDE;
  assign next_sum    = sum_q - old_wide + sample_wide;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
    if (cmd_i.update && !primed_q) begin
      first_q <= sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q  <= 1'b0;
      wrapped_q <= 1'b0;
      wp_q      <= '0;
      sum_q     <= '0;
    end else if (cmd_i.update) begin
      if (!primed_q) begin
        primed_q  <= 1'b1;
        wrapped_q <= 1'b0;
        wp_q      <= '0;
        sum_q     <= prime_sum;
      end else begin
        sum_q <= next_sum;
        if (wp_q == PTR_LAST) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + PTR_W'(1);
        end
      end
    end
  end

  // Divide |sum| by the window length: take the magnitude, then multiply by
  // the reciprocal and keep the integer part.
  assign product = PROD_W'(mag_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= sum_q[SUM_W-1];
      mag_q <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
    end
    if (cmd_i.div_step) begin
      quot_q <= product[SHIFT +: DW];
    end
  end

  assign avg = neg_q ? (~quot_q + DW'(1)) : quot_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= avg;
      out_flag_q <= ($signed(avg) <= $signed(threshold_i));
    end
  end

  assign status_o.out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flag_q;

endmodule

@@ rtl/core/current_moving_average_monitor_top.sv @@
// ----------------------------------------------------------------------------
// current_moving_average_monitor_top
// Boxcar moving-average filter over signed current samples with a low-power
// threshold flag and an APB register for the threshold.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata[15:0] current_sample (signed, 0.1 mA)
//  m_axis   | out       | tdata[15:0] average (signed), tuser[0] low_power
//  apb      | in/out    | reg 0 at 0x0: low_power_threshold[15:0] (signed)
//
//  Each request steps through capture, ring read, sum update, magnitude,
//  reciprocal multiply and load before the next accept; the load step
//  registers its result for m_axis. A waiting result stalls only the load
//  step, so the next request is still taken while that result sits on m_axis.
//  Reset (rst_ni, async, active low) idles the sequencer, unprimes the ring and
//  loads the threshold with 50; the first request after reset primes the window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module current_moving_average_monitor_top #(
  parameter int unsigned WINDOW_LENGTH = cmam_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cmam_pkg::DATA_W-1:0]     s_axis_tdata,  // [15:0] current_sample
  // stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cmam_pkg::DATA_W-1:0]     m_axis_tdata,  // [15:0] average
  output logic                            m_axis_tuser,  // [0] low_power
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmam_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cmam_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cmam_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned DW = cmam_pkg::DATA_W;

  cmam_pkg::cmd_t    dp_cmd;
  cmam_pkg::status_t dp_status;

  logic [DW-1:0]                    threshold_q;
  logic [cmam_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                             reg_write;
  logic                             in_accept;

  // Register decode: word index from the byte address, one register only.
  assign reg_idx   = paddr[cmam_pkg::APB_ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= cmam_pkg::THRESHOLD_RESET;
    end else if (reg_write && (reg_idx == cmam_pkg::REG_LOW_POWER_THRESHOLD)) begin
      threshold_q <= pwdata[DW-1:0];
    end
  end

  // Reads return the threshold sign-extended; unmapped words read zero.
  always_comb begin
    unique case (reg_idx)
      cmam_pkg::REG_LOW_POWER_THRESHOLD: begin
        prdata = {{(cmam_pkg::APB_DATA_W - DW){threshold_q[DW-1]}}, threshold_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // Sequencer: drives s_axis_tready and steps the datapath.
  cmam_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd_o         (dp_cmd),
    .status_i      (dp_status)
  );

  // Ring, running sum, divider and result register.
  cmam_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .sample_i      (s_axis_tdata),
    .threshold_i   (threshold_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // One request in flight: an accept closes the input until the result loads.
  `ASSERT_PROP(a_accept_closes_input, clk_i, rst_ni, in_accept |=> !s_axis_tready)
  // A result must never overwrite one that is still waiting.
  `ASSERT_NEVER(a_no_load_when_full, clk_i, rst_ni, dp_cmd.out_load && !dp_status.out_free)
  // Output valid only rises after the sequencer loads a result.
  `ASSERT_PROP(a_valid_follows_load, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(dp_cmd.out_load))

endmodule
